// ----- rtl/core/drmt_pkg.sv -----
// Shared types and constants for the dirty rectangle merge tracker.
package drmt_pkg;
    localparam int MaxRects   = 64;
    localparam int IdxW       = $clog2(MaxRects);
    localparam int CntW       = $clog2(MaxRects + 1);
    localparam int CoordW     = 13;
    localparam int ScreenLimit = 4096;
    localparam int QueueDepth = 2;

    localparam logic       FuncAdd   = 1'b0;
    localparam logic       FuncFlush = 1'b1;
    localparam logic [0:0] CfgWidth  = 1'b0;
    localparam logic [0:0] CfgHeight = 1'b1;

    typedef struct packed {
        logic [CoordW-1:0] l;
        logic [CoordW-1:0] t;
        logic [CoordW-1:0] r;
        logic [CoordW-1:0] b;
    } t_box;

    typedef struct packed {
        logic flush;
        logic empty;
        t_box box;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_ABS_RD, ST_ABS, ST_MOVE_RD, ST_MOVE,
        ST_COL_RD, ST_COL, ST_COL_WR, ST_FL_RD, ST_FL_OUT
    } t_state;

    function automatic logic box_holds(t_box a, t_box b);
        return a.l <= b.l && a.t <= b.t && a.r >= b.r && a.b >= b.b;
    endfunction

    function automatic logic box_meets(t_box a, t_box b);
        return a.l <= b.r && a.r >= b.l && a.t <= b.b && a.b >= b.t;
    endfunction

    function automatic t_box box_grow(t_box d, t_box s);
        t_box o;
        o.l = (s.l < d.l) ? s.l : d.l;
        o.t = (s.t < d.t) ? s.t : d.t;
        o.r = (s.r > d.r) ? s.r : d.r;
        o.b = (s.b > d.b) ? s.b : d.b;
        return o;
    endfunction
endpackage

// ----- rtl/core/drmt_front.sv -----
// Front end: accepts items, clips rectangles and queues commands.
module drmt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic signed [15:0]   i_rect_left,
    input  logic signed [15:0]   i_rect_top,
    input  logic signed [15:0]   i_rect_width,
    input  logic signed [15:0]   i_rect_height,
    input  logic [12:0]          i_sw,
    input  logic [12:0]          i_sh,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output drmt_pkg::t_cmd       o_cmd
);
    import drmt_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_cmd              r_q [QueueDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;
    logic signed [17:0] w_sw, w_sh, w_l, w_t, w_r, w_b, w_xr, w_yb;
    t_cmd              w_cmd;
    logic              w_push, w_pop;

    always_comb begin
        w_sw = (i_sw > 13'(ScreenLimit)) ? 18'(ScreenLimit) : 18'(i_sw);
        w_sh = (i_sh > 13'(ScreenLimit)) ? 18'(ScreenLimit) : 18'(i_sh);
        w_xr = 18'(i_rect_left) + 18'(i_rect_width);
        w_yb = 18'(i_rect_top) + 18'(i_rect_height);
        w_l  = (i_rect_left < 0) ? 18'sd0 : 18'(i_rect_left);
        w_t  = (i_rect_top < 0) ? 18'sd0 : 18'(i_rect_top);
        w_r  = (w_xr > w_sw) ? w_sw : w_xr;
        w_b  = (w_yb > w_sh) ? w_sh : w_yb;
        w_cmd.flush = (i_func == FuncFlush);
        w_cmd.empty = i_rect_width <= 0 || i_rect_height <= 0 || w_l >= w_r || w_t >= w_b;
        w_cmd.box.l = w_l[CoordW-1:0];
        w_cmd.box.t = w_t[CoordW-1:0];
        w_cmd.box.r = w_r[CoordW-1:0];
        w_cmd.box.b = w_b[CoordW-1:0];
    end

    assign o_ready     = (r_cnt != (PtrW+1)'(QueueDepth));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

// ----- rtl/core/drmt_back.sv -----
// Back end: the rectangle list, its merge sequencer and flush output.
module drmt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  drmt_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [11:0]       o_out_left,
    output logic [11:0]       o_out_top,
    output logic [12:0]       o_out_width,
    output logic [12:0]       o_out_height,
    output logic              o_has_rect,
    output logic              o_last
);
    import drmt_pkg::*;

    t_box              r_mem [MaxRects];
    t_box              r_rd;
    t_state            r_st, n_st;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [IdxW-1:0]   r_i, n_i, r_j, n_j;
    logic [CntW-1:0]   r_k, n_k;
    t_box              r_acc, n_acc, r_nb, n_nb;
    logic              r_ov, n_ov;
    logic [IdxW-1:0]   w_ra;
    logic              w_we;
    logic [IdxW-1:0]   w_wa;
    t_box              w_wd, w_g;
    logic [IdxW-1:0]   w_last;

    assign w_last = r_cnt[IdxW-1:0] - 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
        end
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_acc <= n_acc; r_nb <= n_nb;
    end

    assign o_valid = r_ov;
    assign o_has_rect = (r_cnt != '0) || (r_k != '0);

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_k = r_k;
        n_acc = r_acc; n_nb = r_nb; n_ov = r_ov;
        w_ra = '0; w_we = 1'b0; w_wa = '0; w_wd = r_acc;
        w_g = box_grow(r_acc, r_rd);
        o_cmd_ready = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_nb = i_cmd.box;
                    n_i = '0;
                    n_k = '0;
                    if (i_cmd.flush) begin
                        if (r_cnt == '0) begin
                            n_acc = '0;
                            n_ov = 1'b1;
                            n_st = ST_FL_OUT;
                        end else
                            n_st = ST_FL_RD;
                    end else if (!i_cmd.empty) begin
                        if (r_cnt == '0) begin
                            w_we = 1'b1; w_wa = '0; w_wd = i_cmd.box;
                            n_cnt = CntW'(1);
                        end else
                            n_st = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                w_ra = r_i;
                n_st = ST_SCAN;
            end
            ST_SCAN: begin
                if (box_holds(r_rd, r_nb))
                    n_st = ST_IDLE;
                else if (box_meets(r_rd, r_nb)) begin
                    n_acc = box_grow(r_rd, r_nb);
                    n_j = '0;
                    n_st = ST_ABS_RD;
                end else if (CntW'(r_i) + 1'b1 < r_cnt) begin
                    n_i = r_i + 1'b1;
                    n_st = ST_SCAN_RD;
                end else if (r_cnt < CntW'(MaxRects)) begin
                    w_we = 1'b1; w_wa = r_cnt[IdxW-1:0]; w_wd = r_nb;
                    n_cnt = r_cnt + 1'b1;
                    n_st = ST_IDLE;
                end else begin
                    n_acc = r_nb;
                    n_k = '0;
                    n_st = ST_COL_RD;
                end
            end
            // Merge pass: r_acc holds entry i grown by the new box; it is written back on finish.
            ST_ABS_RD: begin
                if (CntW'(r_j) >= r_cnt || (r_j == '0 && r_cnt == '0)) begin
                    w_we = 1'b1; w_wa = r_i; w_wd = r_acc;
                    n_st = ST_IDLE;
                end else if (r_j == r_i) begin
                    if (CntW'(r_j) + 1'b1 >= r_cnt) begin
                        w_we = 1'b1; w_wa = r_i; w_wd = r_acc;
                        n_st = ST_IDLE;
                    end else
                        n_j = r_j + 1'b1;
                end else begin
                    w_ra = r_j;
                    n_st = ST_ABS;
                end
            end
            ST_ABS: begin
                if (box_meets(r_acc, r_rd)) begin
                    n_acc = w_g;
                    n_cnt = r_cnt - 1'b1;
                    if (w_last == r_i) begin
                        n_i = r_j;
                        n_st = ST_ABS_RD;
                    end else begin
                        n_st = ST_MOVE_RD;
                    end
                end else begin
                    n_st = ST_ABS_RD;
                    if (CntW'(r_j) + 1'b1 >= r_cnt) begin
                        w_we = 1'b1; w_wa = r_i; w_wd = r_acc;
                        n_st = ST_IDLE;
                    end else
                        n_j = r_j + 1'b1;
                end
            end
            ST_MOVE_RD: begin
                // r_cnt already decremented: old last index equals r_cnt.
                w_ra = r_cnt[IdxW-1:0];
                n_st = ST_MOVE;
            end
            ST_MOVE: begin
                w_we = 1'b1; w_wa = r_j; w_wd = r_rd;
                n_st = ST_ABS_RD;
            end
            ST_COL_RD: begin
                w_ra = r_k[IdxW-1:0];
                n_st = ST_COL;
            end
            ST_COL: begin
                n_acc = w_g;
                if (r_k + 1'b1 >= r_cnt) n_st = ST_COL_WR;
                else begin
                    n_k = r_k + 1'b1;
                    n_st = ST_COL_RD;
                end
            end
            ST_COL_WR: begin
                w_we = 1'b1; w_wa = '0; w_wd = r_acc;
                n_cnt = CntW'(1);
                n_st = ST_IDLE;
            end
            ST_FL_RD: begin
                w_ra = r_k[IdxW-1:0];
                n_st = ST_FL_OUT;
                n_ov = 1'b1;
            end
            ST_FL_OUT: begin
                // Keep reading the same entry so a stalled result holds still.
                w_ra = r_k[IdxW-1:0];
                if (r_ov && i_ready) begin
                    n_ov = 1'b0;
                    if (r_cnt == '0 || r_k + 1'b1 >= r_cnt) begin
                        n_cnt = '0;
                        n_k = '0;
                        n_st = ST_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_st = ST_FL_RD;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    t_box w_ob;
    assign w_ob = (r_cnt == '0) ? '0 : r_rd;
    assign o_out_left   = w_ob.l[11:0];
    assign o_out_top    = w_ob.t[11:0];
    assign o_out_width  = w_ob.r - w_ob.l;
    assign o_out_height = w_ob.b - w_ob.t;
    assign o_last       = (r_cnt == '0) || (r_k + 1'b1 >= r_cnt);
endmodule

// ----- rtl/core/dirty_rect_merge_tracker.sv -----
// Top level of the dirty rectangle merge tracker.
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_ready  | func, rect_left/top/width/height
//   out     | output    | o_valid / i_ready  | out_left/top/width/height, has_rect, last
//   cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
// An add scans the stored entries one by one, then a merge pass checks each
// entry and refills each absorbed entry from the end of the list (one memory
// read port); a collapse of a full list reads every entry after the scan.
// A flush reads one entry, presents it and waits until it is taken before it
// reads the next. Reset is synchronous and clears the list count; the store
// needs no clearing. A stalled output holds the back end while the two-entry
// command queue keeps accepting input transfers until it is full.
module dirty_rect_merge_tracker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_func,
    input  logic signed [15:0] i_rect_left,
    input  logic signed [15:0] i_rect_top,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [11:0]  o_out_left,
    output logic [11:0]  o_out_top,
    output logic [12:0]  o_out_width,
    output logic [12:0]  o_out_height,
    output logic         o_has_rect,
    output logic         o_last
);
    import drmt_pkg::*;

    logic [12:0] r_sw, r_sh;
    logic        w_cv, w_cr;
    t_cmd        w_cmd;

    // Screen bounds; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 13'd640;
            r_sh <= 13'd480;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgWidth) r_sw <= i_cfg_data;
            else r_sh <= i_cfg_data;
        end
    end

    drmt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func,
        .i_rect_left, .i_rect_top, .i_rect_width, .i_rect_height,
        .i_sw(r_sw), .i_sh(r_sh),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    drmt_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_out_left, .o_out_top, .o_out_width,
        .o_out_height, .o_has_rect, .o_last
    );
endmodule

// ----- rtl/core/drmt_checker.sv -----
// Port level checks for the dirty rectangle merge tracker.
module drmt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_has_rect,
    input logic o_last,
    input logic [12:0] o_out_width
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("valid dropped");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_rect |-> o_last) else $error("empty not last");
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_rect |-> o_out_width != 13'd0) else $error("zero width");
endmodule

bind dirty_rect_merge_tracker drmt_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_has_rect, .o_last, .o_out_width
);
